[hw/rtl/irs_pkg.sv]
// irs_pkg: shared types and constants for the integer image rescaler.
// Holds the stream word layouts, the emitter request and the register indexes.
// No dependencies; compiled first.
package irs_pkg;

  // Pixel and field widths
  localparam int COMP_W     = 8;
  localparam int RGB_W      = 3 * COMP_W;
  // Scale register width, also the width of a copy count (scale never exceeds 8)
  localparam int COPY_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  // Row counter reach
  localparam int ROW_CNT_W  = 11;
  localparam int ROWS_W     = 12;
  localparam logic [ROWS_W-1:0] ROW_LIMIT = 12'd2048;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS  = 2'd3;

  // Direction and input mode codes
  localparam logic DIR_DOWN     = 1'b0;
  localparam logic DIR_UP       = 1'b1;
  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [COMP_W-1:0] red_out;
    logic [COMP_W-1:0] green_out;
    logic [COMP_W-1:0] blue_out;
    logic              run_last;
    logic              row_end;
    logic              frame_end;
  } pix_out_t;

  // One burst of identical output words, handed from the control to the emitter
  typedef struct packed {
    logic [RGB_W-1:0]  rgb;
    logic              from_mem;
    logic [COPY_W-1:0] count;
    logic              rend;
    logic              fend;
  } emit_req_t;

endpackage

[hw/rtl/irs_stream_if.sv]
// irs_stream_if: valid/ready stream channel carrying one payload word.
// The payload type is set where the channel is instantiated (irs_pkg types).
// No dependencies.
interface irs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/irs_emit.sv]
// irs_emit: replicates one pixel into a burst of output words, one per cycle unless
// ready stalls, via a registered output stage. Depends on irs_pkg and irs_stream_if.
module irs_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  irs_pkg::emit_req_t           req,
  input  logic [irs_pkg::RGB_W-1:0]    mem_data,
  output logic                         can_load,
  irs_stream_if.source                 scaled
);
  import irs_pkg::*;

  logic              busy;
  logic [COPY_W-1:0] left;
  logic              from_mem;
  logic [RGB_W-1:0]  rgb;
  logic              rend;
  logic              fend;
  logic              o_valid;
  pix_out_t          o_word;

  logic              take_ok;
  logic              step;
  logic              final_copy;
  logic [RGB_W-1:0]  cur_rgb;

  // Output register frees when empty or being taken
  assign take_ok    = !o_valid || scaled.ready;
  assign step       = busy && take_ok;
  assign final_copy = (left == COPY_W'(1));
  assign can_load   = !busy || (step && final_copy);
  // Replay words come from the line store read register, held until next load
  assign cur_rgb    = from_mem ? mem_data : rgb;

  // Burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (step && final_copy) begin
      busy <= 1'b0;
    end
  end

  // Burst payload and copy count
  always_ff @(posedge clk) begin
    if (load) begin
      left     <= req.count;
      from_mem <= req.from_mem;
      rgb      <= req.rgb;
      rend     <= req.rend;
      fend     <= req.fend;
    end else if (step) begin
      left <= left - COPY_W'(1);
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (take_ok) begin
      o_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_word.red_out   <= cur_rgb[2*COMP_W +: COMP_W];
      o_word.green_out <= cur_rgb[COMP_W +: COMP_W];
      o_word.blue_out  <= cur_rgb[0 +: COMP_W];
      o_word.run_last  <= final_copy;
      o_word.row_end   <= final_copy && rend;
      o_word.frame_end <= final_copy && fend;
    end
  end

  assign scaled.valid   = o_valid;
  assign scaled.payload = o_word;

  // A new burst is never loaded over one still in flight
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> can_load)
    else $error("burst loaded while emitter busy");
  // A live burst always owes at least one word
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (left != '0))
    else $error("emitter busy with no copies left");
  // Frame end only on the last word of a row and of its burst
  a_frame_marks: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_word.frame_end) |-> (o_word.row_end && o_word.run_last))
    else $error("frame_end without row_end and run_last");

endmodule

[hw/rtl/integer_image_rescale.sv]
// Channel   | Dir  | Word                                  | Accepted when
// pixel     | in   | mode, red_in, green_in, blue_in       | pixel.valid && pixel.ready
// scaled    | out  | rgb, run_last, row_end, frame_end     | scaled.valid && scaled.ready
// cfg       | in   | cfg_index, cfg_data                   | cfg_wr_en
//
// Down mode takes one word a cycle while not stalled and gives at most one word per input.
// Up mode gives scale words (1 to 8) per pixel stored or replayed, one a cycle unless
// stalled; the single output port takes the next input word as a burst's last word issues.
// Line store: one synchronous RAM, written by pixels, read by advance words into a register.
// No clearing pass after reset: replays only read entries written earlier in the same row.
// The output register lets the next input be taken while the last word waits on ready.
// Depends on irs_pkg, irs_stream_if and irs_emit.
module integer_image_rescale #(
  parameter int MAX_COLS  = 2048,
  parameter int MAX_SCALE = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [irs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irs_pkg::CFG_DATA_W-1:0]    cfg_data,
  irs_stream_if.sink                        pixel,
  irs_stream_if.source                      scaled
);
  import irs_pkg::*;

  localparam int AW    = $clog2(MAX_COLS);
  localparam int EC_W  = $clog2(MAX_COLS + 1);
  localparam int CMP_W = (EC_W > CFG_DATA_W) ? EC_W : CFG_DATA_W;
  localparam int DC_W  = EC_W + 2;
  localparam int DR_W  = ROWS_W + 2;
  localparam int PH_W  = $clog2(MAX_SCALE);

  // Effective configuration, clamped at write time
  logic              direction;
  logic [COPY_W-1:0] eff_scale;
  logic [EC_W-1:0]   eff_cols;
  logic [ROWS_W-1:0] eff_rows;

  // Position state
  logic [AW-1:0]        src_col_count, src_col_count_next;
  logic [ROW_CNT_W-1:0] src_row_count, src_row_count_next;
  logic [PH_W-1:0]      col_phase, col_phase_next;
  logic [PH_W-1:0]      row_phase, row_phase_next;
  logic [AW-1:0]        replay_index, replay_index_next;
  logic [PH_W-1:0]      replays_left, replays_left_next;

  // Line store
  logic [RGB_W-1:0] line_store [MAX_COLS];
  logic [RGB_W-1:0] rd_data;
  logic             mem_we;
  logic             mem_re;

  logic              cfg_known;
  logic [COPY_W-1:0] cfg_scale_raw;
  logic [COPY_W-1:0] cfg_scale_eff;
  logic [CMP_W-1:0]  cfg_cols_wide;
  logic [EC_W-1:0]   cfg_cols_eff;
  logic [ROWS_W-1:0] cfg_rows_eff;

  logic              acc;
  logic              emit_can_load;
  logic              req_load;
  emit_req_t         req;
  pix_in_t           word_in;
  logic [RGB_W-1:0]  rgb_in;

  logic [EC_W-1:0]   col_plus1;
  logic [EC_W-1:0]   ri_plus1;
  logic              col_wrap;
  logic              ri_wrap;
  logic [ROWS_W-1:0] row_plus1;
  logic              row_last;
  logic              col_fit, col_lastgrp;
  logic              row_fit, row_lastgrp;
  logic              cph_wrap, rph_wrap;
  logic [ROW_CNT_W-1:0] row_adv;

  // Clamp the written value of each register
  assign cfg_scale_raw = cfg_data[COPY_W-1:0];
  assign cfg_scale_eff = (cfg_scale_raw == '0) ? COPY_W'(1) :
                         (cfg_scale_raw > COPY_W'(MAX_SCALE)) ? COPY_W'(MAX_SCALE) :
                         cfg_scale_raw;
  assign cfg_cols_wide = CMP_W'(cfg_data);
  assign cfg_cols_eff  = (cfg_cols_wide == '0) ? EC_W'(1) :
                         (cfg_cols_wide > CMP_W'(MAX_COLS)) ? EC_W'(MAX_COLS) :
                         EC_W'(cfg_cols_wide);
  assign cfg_rows_eff  = (cfg_data == '0) ? ROWS_W'(1) :
                         (cfg_data > ROW_LIMIT) ? ROW_LIMIT : cfg_data;

  always_comb begin
    unique case (cfg_index)
      REG_DIRECTION, REG_SCALE, REG_SRC_COLS, REG_SRC_ROWS: cfg_known = cfg_wr_en;
      default:                                              cfg_known = 1'b0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_DOWN;
      eff_scale <= COPY_W'(1);
      eff_cols  <= EC_W'(1);
      eff_rows  <= ROWS_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIRECTION: direction <= cfg_data[0];
        REG_SCALE:     eff_scale <= cfg_scale_eff;
        REG_SRC_COLS:  eff_cols  <= cfg_cols_eff;
        REG_SRC_ROWS:  eff_rows  <= cfg_rows_eff;
        default:       ;
      endcase
    end
  end

  assign word_in     = pixel.payload;
  assign rgb_in      = {word_in.red_in, word_in.green_in, word_in.blue_in};
  assign pixel.ready = emit_can_load;
  assign acc         = pixel.valid && emit_can_load;

  // Position arithmetic: no division, group fits are checked by adding scale
  assign col_plus1   = EC_W'(src_col_count) + EC_W'(1);
  assign ri_plus1    = EC_W'(replay_index) + EC_W'(1);
  assign col_wrap    = (col_plus1 == eff_cols);
  assign ri_wrap     = (ri_plus1 == eff_cols);
  assign row_plus1   = ROWS_W'(src_row_count) + ROWS_W'(1);
  assign row_last    = (row_plus1 == eff_rows);
  assign row_adv     = row_last ? '0 : ROW_CNT_W'(row_plus1);
  assign col_fit     = (DC_W'(src_col_count) + DC_W'(eff_scale)) <= DC_W'(eff_cols);
  assign col_lastgrp = (DC_W'(src_col_count) + (DC_W'(eff_scale) << 1)) > DC_W'(eff_cols);
  assign row_fit     = (DR_W'(src_row_count) + DR_W'(eff_scale)) <= DR_W'(eff_rows);
  assign row_lastgrp = (DR_W'(src_row_count) + (DR_W'(eff_scale) << 1)) > DR_W'(eff_rows);
  assign cph_wrap    = (COPY_W'(col_phase) + COPY_W'(1)) >= eff_scale;
  assign rph_wrap    = (COPY_W'(row_phase) + COPY_W'(1)) >= eff_scale;

  // Per-word decision and next position
  always_comb begin
    src_col_count_next = src_col_count;
    src_row_count_next = src_row_count;
    col_phase_next     = col_phase;
    row_phase_next     = row_phase;
    replay_index_next  = replay_index;
    replays_left_next  = replays_left;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    req_load           = 1'b0;
    req.rgb            = rgb_in;
    req.from_mem       = 1'b0;
    req.count          = eff_scale;
    req.rend           = 1'b0;
    req.fend           = 1'b0;
    if (acc) begin
      if (direction == DIR_DOWN) begin
        if (word_in.mode == MODE_PIXEL) begin
          // Keep the first pixel of each whole group
          if (col_phase == '0 && row_phase == '0 && col_fit && row_fit) begin
            req_load  = 1'b1;
            req.count = COPY_W'(1);
            req.rend  = col_lastgrp;
            req.fend  = col_lastgrp && row_lastgrp;
          end
          src_col_count_next = AW'(col_plus1);
          col_phase_next     = cph_wrap ? '0 : col_phase + PH_W'(1);
          if (col_wrap) begin
            src_col_count_next = '0;
            col_phase_next     = '0;
            row_phase_next     = rph_wrap ? '0 : row_phase + PH_W'(1);
            src_row_count_next = row_adv;
            if (row_last) begin
              row_phase_next = '0;
            end
          end
        end
      end else if (word_in.mode == MODE_PIXEL) begin
        // Source pixel, ignored while a replay is owed
        if (replays_left == '0) begin
          mem_we   = 1'b1;
          req_load = 1'b1;
          req.rend = col_wrap;
          req.fend = col_wrap && (eff_scale == COPY_W'(1)) && row_last;
          src_col_count_next = AW'(col_plus1);
          if (col_wrap) begin
            src_col_count_next = '0;
            if (eff_scale > COPY_W'(1)) begin
              replays_left_next = PH_W'(eff_scale - COPY_W'(1));
              replay_index_next = '0;
            end else begin
              src_row_count_next = row_adv;
            end
          end
        end
      end else begin
        // Advance: replay one stored pixel
        if (replays_left != '0) begin
          mem_re       = 1'b1;
          req_load     = 1'b1;
          req.from_mem = 1'b1;
          req.rend     = ri_wrap;
          req.fend     = ri_wrap && (replays_left == PH_W'(1)) && row_last;
          replay_index_next = AW'(ri_plus1);
          if (ri_wrap) begin
            replay_index_next = '0;
            replays_left_next = replays_left - PH_W'(1);
            if (replays_left == PH_W'(1)) begin
              src_row_count_next = row_adv;
            end
          end
        end
      end
    end
  end

  // Position registers; any known register write starts a new frame
  always_ff @(posedge clk) begin
    if (rst || cfg_known) begin
      src_col_count <= '0;
      src_row_count <= '0;
      col_phase     <= '0;
      row_phase     <= '0;
      replay_index  <= '0;
      replays_left  <= '0;
    end else if (acc) begin
      src_col_count <= src_col_count_next;
      src_row_count <= src_row_count_next;
      col_phase     <= col_phase_next;
      row_phase     <= row_phase_next;
      replay_index  <= replay_index_next;
      replays_left  <= replays_left_next;
    end
  end

  // Line store; a write and a read never share a cycle, so no bypass is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[src_col_count] <= rgb_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= line_store[replay_index];
    end
  end

  irs_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (req_load),
    .req      (req),
    .mem_data (rd_data),
    .can_load (emit_can_load),
    .scaled   (scaled)
  );

  // Column position always inside the configured width
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    EC_W'(src_col_count) < eff_cols)
    else $error("source column beyond width");
  a_replay_bound: assert property (@(posedge clk) disable iff (rst)
    EC_W'(replay_index) < eff_cols)
    else $error("replay column beyond width");
  // Replays are only owed in up mode
  a_replay_up: assert property (@(posedge clk) disable iff (rst)
    (replays_left != '0) |-> (direction == DIR_UP))
    else $error("replay pending in down mode");
  // A line store read only ever feeds a new burst
  a_read_loads: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (req_load && req.from_mem))
    else $error("line store read without a replay burst");

endmodule

[dv/testbench.sv]
// Self-checking bench for integer_image_rescale: directed and random pixel streams with
// a predictor of the expected output word sequence, random idling on both channels.
// Depends on irs_pkg, irs_stream_if and the integer_image_rescale RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irs_pkg::*;

  localparam int unsigned MAX_COLS      = 2048;
  localparam int unsigned MAX_SCALE     = 8;
  localparam int unsigned RANDOM_ITEMS  = 120;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned REPORT_CAP    = 40;

  // Clock, reset and configuration port
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Channel drive
  logic    pix_valid = 1'b0;
  pix_in_t pix_word  = '0;
  logic    out_ready = 1'b0;

  irs_stream_if #(.payload_t(pix_in_t))  pixel_ch ();
  irs_stream_if #(.payload_t(pix_out_t)) scaled_ch ();

  assign pixel_ch.valid   = pix_valid;
  assign pixel_ch.payload = pix_word;
  assign scaled_ch.ready  = out_ready;

  integer_image_rescale i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel_ch),
    .scaled    (scaled_ch)
  );

  always #5 clk = ~clk;

  // Register copies as written
  logic                  cur_dir;
  logic [3:0]            cur_scale;
  logic [CFG_DATA_W-1:0] cur_cols;
  logic [CFG_DATA_W-1:0] cur_rows;

  // Predicted position state
  logic [RGB_W-1:0] line_copy [MAX_COLS];
  int unsigned      col_cnt, row_cnt, col_ph, row_ph, replay_col, passes_owed;

  pix_in_t     pending_words [$];
  pix_out_t    expected_words [$];
  logic        word_on_offer = 1'b0;
  int unsigned gap_left, stall_left, source_calm, sink_calm;
  int unsigned words_taken, words_checked, mismatches, settings_used, cycle_count;

  // Zero and oversize register values fold to the usable range
  function automatic int unsigned clamp_to(int unsigned v, int unsigned top);
    return (v == 0) ? 1 : ((v > top) ? top : v);
  endfunction

  // Idle draw: occasional stretches with no idling at all
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic void push_copies(logic [RGB_W-1:0] rgb, int unsigned copies,
                                      logic rend, logic fend);
    pix_out_t w;
    for (int unsigned i = 0; i < copies; i++) begin
      w.red_out   = rgb[23:16];
      w.green_out = rgb[15:8];
      w.blue_out  = rgb[7:0];
      w.run_last  = (i + 1 == copies);
      w.row_end   = w.run_last && rend;
      w.frame_end = w.run_last && fend;
      expected_words = {expected_words, w};
    end
  endfunction

  function automatic void step_row(int unsigned rows);
    row_cnt++;
    if (row_cnt >= rows) row_cnt = 0;
  endfunction

  // Expected output words for one accepted pixel word
  function automatic void predict_word(pix_in_t w);
    int unsigned      s, cols, rows, ocols, orows;
    logic [RGB_W-1:0] rgb;
    logic             rend, fend;
    s    = clamp_to(cur_scale, MAX_SCALE);
    cols = clamp_to(cur_cols, MAX_COLS);
    rows = clamp_to(cur_rows, ROW_LIMIT);
    rgb  = {w.red_in, w.green_in, w.blue_in};
    if (cur_dir == DIR_DOWN) begin
      // decimation: keep the word at each multiple of scale, drop leftovers
      if (w.mode == MODE_PIXEL) begin
        ocols = cols / s;
        orows = rows / s;
        if (col_ph == 0 && row_ph == 0 && col_cnt < ocols * s && row_cnt < orows * s) begin
          rend = (col_cnt / s + 1 == ocols);
          fend = rend && (row_cnt / s + 1 == orows);
          push_copies(rgb, 1, rend, fend);
        end
        col_cnt++;
        col_ph++;
        if (col_ph >= s) col_ph = 0;
        if (col_cnt >= cols) begin
          col_cnt = 0;
          col_ph  = 0;
          row_ph++;
          if (row_ph >= s) row_ph = 0;
          step_row(rows);
          if (row_cnt == 0) row_ph = 0;
        end
      end
    end else if (w.mode == MODE_PIXEL) begin
      // source pixel; ignored while the row is still owed replays
      if (passes_owed == 0) begin
        line_copy[col_cnt] = rgb;
        rend = (col_cnt + 1 == cols);
        fend = rend && (s == 1) && (row_cnt + 1 == rows);
        push_copies(rgb, s, rend, fend);
        col_cnt++;
        if (col_cnt >= cols) begin
          col_cnt = 0;
          if (s > 1) begin
            passes_owed = s - 1;
            replay_col  = 0;
          end else begin
            step_row(rows);
          end
        end
      end
    end else if (passes_owed != 0) begin
      // advance: replay one stored pixel of the row
      rend = (replay_col + 1 == cols);
      fend = rend && (passes_owed == 1) && (row_cnt + 1 == rows);
      push_copies(line_copy[replay_col], s, rend, fend);
      replay_col++;
      if (replay_col >= cols) begin
        replay_col = 0;
        passes_owed--;
        if (passes_owed == 0) step_row(rows);
      end
    end
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_word(pix_out_t got);
    pix_out_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: output word with none expected, expected nothing, got %h", $time, got);
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("run_last", want.run_last, got.run_last);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("frame_end", want.frame_end, got.frame_end);
    end
  endfunction

  // Pixel channel driver
  always @(posedge clk) begin
    if (rst) begin
      word_on_offer = 1'b0;
      gap_left      = 0;
      pix_valid     <= 1'b0;
    end else begin
      if (pix_valid && pixel_ch.ready) begin
        predict_word(pix_word);
        words_taken++;
        word_on_offer = 1'b0;
        gap_left      = draw_wait(source_calm);
      end
      if (!word_on_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          pix_word      <= pending_words.pop_front();
          word_on_offer = 1'b1;
        end
      end
      pix_valid <= word_on_offer;
    end
  end

  // Output channel monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_ready  <= 1'b0;
    end else begin
      if (scaled_ch.valid && out_ready) begin
        check_word(scaled_ch.payload);
        stall_left = draw_wait(sink_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_pixel(logic [RGB_W-1:0] rgb);
    pending_words = {pending_words, pix_in_t'({MODE_PIXEL, rgb})};
  endfunction

  // Colour fields of an advance word carry noise
  function automatic void queue_advance();
    pending_words = {pending_words, pix_in_t'({MODE_ADVANCE, RGB_W'($urandom)})};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DIRECTION: cur_dir   = data[0];
      REG_SCALE:     cur_scale = data[3:0];
      REG_SRC_COLS:  cur_cols  = data;
      REG_SRC_ROWS:  cur_rows  = data;
      default: ;
    endcase
    // any write starts a new frame
    col_cnt     = 0;
    row_cnt     = 0;
    col_ph      = 0;
    row_ph      = 0;
    replay_col  = 0;
    passes_owed = 0;
  endtask

  // All four registers, unused upper data bits random
  task automatic set_config(input logic dir, input logic [3:0] scale,
                            input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_DIRECTION, {junk[CFG_DATA_W-1:1], dir});
    write_reg(REG_SCALE, {junk[CFG_DATA_W-1:4], scale});
    write_reg(REG_SRC_COLS, cols);
    write_reg(REG_SRC_ROWS, rows);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Drain: nothing queued, nothing on offer, nothing expected, then let ignored words settle
  task automatic wait_idle();
    while (pending_words.size() > 0 || word_on_offer || expected_words.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic                  dir;
    logic [3:0]            scale_w;
    logic [CFG_DATA_W-1:0] cols_w, rows_w;
    int unsigned           s, c, r, row_len, run_len, random_items;
    logic                  in_replay;

    cur_dir   = DIR_DOWN;
    cur_scale = 4'd1;
    cur_cols  = 12'd1;
    cur_rows  = 12'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 1x1 frame, every pixel is a frame end; advance does nothing
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_advance();
    wait_idle();

    // up by 3 on a 2x1 frame: pixel during replay, full replay, stray advance, frame wrap
    set_config(DIR_UP, 4'd3, 12'd2, 12'd1);
    queue_pixel(24'hFF0000);
    queue_pixel(24'h00FF00);
    queue_pixel(24'h0000FF);
    repeat (4) queue_advance();
    queue_advance();
    queue_pixel(24'hFF00FF);
    wait_idle();

    // zero scale and zero sizes fold to 1
    set_config(DIR_UP, 4'd0, 12'd0, 12'd0);
    queue_pixel(24'h55AA55);
    queue_pixel(24'hAA55AA);
    queue_advance();
    wait_idle();

    // scale above the maximum, and larger than the frame: nothing comes out
    set_config(DIR_DOWN, 4'd15, 12'd3, 12'd3);
    repeat (4) queue_pixel(24'($urandom));
    wait_idle();

    // largest burst: scale 8 on a single pixel, seven replay passes
    set_config(DIR_UP, 4'd8, 12'd1, 12'd1);
    queue_pixel(24'($urandom));
    repeat (7) queue_advance();
    wait_idle();

    // random settings, mostly well-formed frames with stray words of the other kind
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      dir     = 1'($urandom_range(0, 1));
      scale_w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 4));
      cols_w  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 7))
                                            : 12'($urandom_range(1, 5));
      rows_w  = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 6))
                                            : 12'($urandom_range(1, 4));
      set_config(dir, scale_w, cols_w, rows_w);
      s = clamp_to(scale_w, MAX_SCALE);
      c = clamp_to(cols_w, MAX_COLS);
      r = clamp_to(rows_w, ROW_LIMIT);
      row_len = (dir == DIR_UP) ? s * c : c;
      run_len = $urandom_range(1, 2) * r * row_len;
      // long frames and some others are cut short
      if (run_len > 96) run_len = $urandom_range(48, 96);
      else if ($urandom_range(0, 5) == 0) run_len = $urandom_range(1, run_len);
      for (int unsigned k = 0; k < run_len; k++) begin
        in_replay = (dir == DIR_UP) && (k % row_len >= c);
        if ($urandom_range(0, 9) == 0) begin
          if (in_replay) queue_pixel(24'($urandom));
          else queue_advance();
        end
        if (in_replay) queue_advance();
        else queue_pixel(24'($urandom));
      end
      random_items += run_len;
      wait_idle();
    end

    // oversize width saturates: no row end within the first few words
    set_config(DIR_DOWN, 4'd1, 12'd4095, 12'd2);
    repeat (8) queue_pixel(24'($urandom));
    wait_idle();

    // oversize height saturates: no frame end within the first few rows
    set_config(DIR_DOWN, 4'd1, 12'd1, 12'd4095);
    repeat (8) queue_pixel(24'($urandom));
    wait_idle();

    $display("%0d pixel words taken, %0d output words checked over %0d register settings",
             words_taken, words_checked, settings_used);
    $display("register values from zero to beyond their limits, scales 0 to 15, both directions");
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached, %0d words still expected", $time, expected_words.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
